// ===== rtl/ctip_pkg.sv =====
// Package for the clamped target interpolator: sequencer state codes,
// register indexes, Q16.16 constants and register reset values.
// No dependencies.
package ctip_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned WT_W    = 17;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = 65;

  localparam logic [WT_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic signed [DATA_W-1:0] LIM_LO_RST     = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] LIM_HI_RST     = 32'sh7FFF_FFFF;
  localparam logic [CFG_W-1:0]         TOLERANCE_RST  = 31'd66;
  localparam logic [CFG_W-1:0]         INV_TIME_RST   = 31'd93623;

  typedef enum logic [1:0] {
    REG_LIM_LO       = 2'd0,
    REG_LIM_HI       = 2'd1,
    REG_TOLERANCE    = 2'd2,
    REG_INVERSE_TIME = 2'd3
  } cfg_reg_t;

  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CLAMP   = 8'b0000_0010,
    S_CMP     = 8'b0000_0100,
    S_MUL_INC = 8'b0000_1000,
    S_WT      = 8'b0001_0000,
    S_MUL_MIX = 8'b0010_0000,
    S_MIX     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/clamped_target_interpolator_core.sv =====
// Clamped target interpolator: Q16.16 exponential smoothing toward a
// clamped goal, built around one shared 33x32 signed multiplier.
// Depends on ctip_pkg.
// From accept to result valid: set-target goes through CLAMP, CMP and
// DONE; an active tick through MUL_INC, WT, MUL_MIX, MIX and DONE; an idle
// tick straight to DONE. One item in flight; the sequencer runs two
// passes through the multiplier per active tick (increment, then blend).
// New items wait until DONE loads the result, once the old one is taken.
// rst (synchronous) restores register defaults and clears value, goal,
// weight and the active flag.
module clamped_target_interpolator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [ctip_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [ctip_pkg::DATA_W-1:0]  operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ctip_pkg::DATA_W-1:0]  current_value,
  output logic [ctip_pkg::WT_W-1:0]           blend_weight,
  output logic                                busy_res
);

  localparam int unsigned DW = ctip_pkg::DATA_W;
  localparam int unsigned WW = ctip_pkg::WT_W;
  localparam int unsigned PW = ctip_pkg::PROD_W;
  localparam int unsigned FW = ctip_pkg::FRAC_W;
  localparam int unsigned IW = PW - FW;

  ctip_pkg::state_t state;

  logic signed [DW-1:0]          lim_lo;
  logic signed [DW-1:0]          lim_hi;
  logic [ctip_pkg::CFG_W-1:0]    tolerance;
  logic [ctip_pkg::CFG_W-1:0]    inverse_time;

  logic signed [DW-1:0]  current;
  logic signed [DW-1:0]  goal;
  logic [WW-1:0]         weight;
  logic                  active;

  logic signed [DW-1:0]  x;
  logic signed [DW:0]    diff;
  logic signed [PW-1:0]  prod;

  logic signed [DW:0]    mul_a;
  logic signed [DW-1:0]  mul_b;
  logic signed [DW:0]    delta;
  logic signed [DW:0]    delta_abs;
  logic                  far;
  logic signed [IW-1:0]  inc;
  logic signed [IW:0]    wsum;
  logic [WW-1:0]         wsat;
  logic                  out_free;

  assign in_ready = (state == ctip_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  // shared multiplier operand select
  always_comb begin
    if (state == ctip_pkg::S_MUL_MIX) begin
      mul_a = diff;
      mul_b = $signed({{(DW-WW){1'b0}}, weight});
    end else begin
      mul_a = (DW+1)'(x);
      mul_b = $signed({1'b0, inverse_time});
    end
  end

  always_comb begin
    delta     = (DW+1)'(goal) - (DW+1)'(x);
    delta_abs = (delta < 0) ? -delta : delta;
    far       = delta_abs > $signed({2'b00, tolerance});
    inc       = $signed(prod[PW-1:FW]);
    wsum      = $signed({{(IW+1-WW){1'b0}}, weight}) + (IW+1)'(inc);
    if (wsum < 0) begin
      wsat = '0;
    end else if (wsum > $signed({{(IW+1-WW){1'b0}}, ctip_pkg::ONE_Q16})) begin
      wsat = ctip_pkg::ONE_Q16;
    end else begin
      wsat = wsum[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_lo       <= ctip_pkg::LIM_LO_RST;
      lim_hi       <= ctip_pkg::LIM_HI_RST;
      tolerance    <= ctip_pkg::TOLERANCE_RST;
      inverse_time <= ctip_pkg::INV_TIME_RST;
    end else if (cfg_we) begin
      unique case (ctip_pkg::cfg_reg_t'(cfg_index))
        ctip_pkg::REG_LIM_LO:       lim_lo       <= $signed(cfg_data);
        ctip_pkg::REG_LIM_HI:       lim_hi       <= $signed(cfg_data);
        ctip_pkg::REG_TOLERANCE:    tolerance    <= cfg_data[ctip_pkg::CFG_W-1:0];
        ctip_pkg::REG_INVERSE_TIME: inverse_time <= cfg_data[ctip_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ctip_pkg::S_IDLE: begin
        if (in_valid) x <= operand;
      end
      ctip_pkg::S_CLAMP: begin
        if (x > lim_hi) begin
          x <= lim_hi;
        end else if (x < lim_lo) begin
          x <= lim_lo;
        end
      end
      ctip_pkg::S_MUL_INC, ctip_pkg::S_MUL_MIX: begin
        prod <= PW'(mul_a) * PW'(mul_b);
      end
      ctip_pkg::S_WT: begin
        diff <= (DW+1)'(goal) - (DW+1)'(current);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ctip_pkg::S_IDLE;
      current   <= '0;
      goal      <= '0;
      weight    <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ctip_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ctip_pkg::S_IDLE: begin
          if (in_valid) begin
            if (op == ctip_pkg::OP_SET_TARGET) begin
              state <= ctip_pkg::S_CLAMP;
            end else if (active) begin
              state <= ctip_pkg::S_MUL_INC;
            end else begin
              weight <= '0;
              state  <= ctip_pkg::S_DONE;
            end
          end
        end
        ctip_pkg::S_CLAMP:   state <= ctip_pkg::S_CMP;
        ctip_pkg::S_CMP: begin
          if (far) begin
            goal   <= x;
            weight <= weight >> 2;
            active <= 1'b1;
          end
          state <= ctip_pkg::S_DONE;
        end
        ctip_pkg::S_MUL_INC: state <= ctip_pkg::S_WT;
        ctip_pkg::S_WT: begin
          weight <= wsat;
          state  <= ctip_pkg::S_MUL_MIX;
        end
        ctip_pkg::S_MUL_MIX: state <= ctip_pkg::S_MIX;
        ctip_pkg::S_MIX: begin
          // convex blend: current + floor(w * (goal - current) / 1.0)
          current <= current + $signed(prod[FW+DW-1:FW]);
          if (weight == ctip_pkg::ONE_Q16) active <= 1'b0;
          state <= ctip_pkg::S_DONE;
        end
        ctip_pkg::S_DONE: begin
          if (out_free) state <= ctip_pkg::S_IDLE;
        end
        default: state <= ctip_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ctip_pkg::S_DONE && out_free) begin
      current_value <= current;
      blend_weight  <= weight;
      busy_res      <= active;
    end
  end

endmodule
